// ===== design/mlfq_pkg.sv =====
package mlfq_pkg;

	// Scheduler dimensions.
	localparam int NUM_LEVELS = 5;
	localparam int MAX_PROCS = 16;
	localparam int NQ = NUM_LEVELS + 1;
	localparam int WAITQ = NUM_LEVELS;

	// Field widths.
	localparam int PID_W = 4;
	localparam int LVL_W = 3;
	localparam int RT_W = 11;
	localparam int REM_W = RT_W + 1;
	localparam int QIDX_W = $clog2(NQ);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	// Request codes.
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_ADMIT = 1'b1;
	localparam logic [2:0] PHASE_START = 3'd4;
	localparam logic [2:0] PHASE_END = 3'd1;

	typedef logic [PID_W-1:0] pid_t;
	typedef logic [LVL_W-1:0] lvl_t;
	typedef logic [QIDX_W-1:0] qidx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [REM_W-1:0] rem_t;

	localparam rem_t REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

	typedef struct packed {
		logic action;
		logic [3:0] proc_id;
		logic [10:0] run_time;
		logic io_request;
		logic [1:0] io_ticks;
		logic [2:0] burst_phase;
	} cmd_t;

	typedef struct packed {
		logic run_valid;
		logic [3:0] run_id;
		logic [2:0] run_level;
		logic exited_valid;
		logic [3:0] exited_id;
		logic io_done_valid;
		logic [3:0] io_done_id;
		logic all_idle;
	} res_t;

	// One process entry of the slot memory.
	typedef struct packed {
		lvl_t level;
		rem_t remaining;
		logic [1:0] wait_left;
	} proc_ent_t;

	// Result of a priority search over the run queues.
	typedef struct packed {
		logic found;
		lvl_t level;
	} pick_t;

endpackage

// ===== design/mlfq_if.sv =====
interface mlfq_cmd_if;
	import mlfq_pkg::*;
	logic valid;
	logic ready;
	cmd_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface mlfq_res_if;
	import mlfq_pkg::*;
	logic valid;
	logic ready;
	res_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== design/mlfq_pick.sv =====
module mlfq_pick (
	input mlfq_pkg::cnt_t cnt [mlfq_pkg::NQ],
	output mlfq_pkg::pick_t pick
);
	import mlfq_pkg::*;

	// The highest-numbered non-empty run level wins.
	always_comb begin
		pick = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (cnt[l] != '0) begin
				pick.found = 1'b1;
				pick.level = lvl_t'(l);
			end
		end
	end
endmodule

// ===== design/mlfq_core.sv =====
module mlfq_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	input mlfq_pkg::cmd_t cmd,
	input logic slot_free,
	output logic idle,
	output logic done,
	output mlfq_pkg::res_t res
);
	import mlfq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ADMIT, S_WAIT_RD, S_WAIT_UPD, S_SEL,
		S_RUN_RD, S_RUN_UPD, S_RESEL, S_IO_RUN, S_FINISH
	} state_t;

	state_t state_q, state_n;
	cmd_t cmd_q, cmd_n;
	res_t res_q, res_n;
	pid_t head_q [NQ], head_n [NQ];
	pid_t tail_q [NQ], tail_n [NQ];
	cnt_t cnt_q [NQ], cnt_n [NQ];
	logic [MAX_PROCS-1:0] resident_q, resident_n;
	lvl_t sel_lvl_q, sel_lvl_n;
	logic sel_live_q, sel_live_n;
	logic first_q, first_n;
	logic just_exited_q, just_exited_n;
	logic act_q, act_n;
	pid_t p_q, p_n;

	// Slot memories and their read ports.
	proc_ent_t proc_mem [MAX_PROCS];
	pid_t link_mem [MAX_PROCS];
	proc_ent_t proc_rd_q;
	pid_t link_rd_q;
	logic rd_en;
	pid_t rd_addr;
	logic proc_we;
	pid_t proc_wa;
	proc_ent_t proc_wd;
	logic link_we;
	pid_t link_wa;
	pid_t link_wd;

	pick_t pick;
	logic all_empty;

	mlfq_pick u_pick (
		.cnt(cnt_q),
		.pick(pick)
	);

	// All queues empty, taken from the registered counts.
	always_comb begin
		all_empty = 1'b1;
		for (int q = 0; q < NQ; q++) begin
			if (cnt_q[q] != '0) all_empty = 1'b0;
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_FINISH) && slot_free;

	always_comb begin
		res = res_q;
		res.all_idle = all_empty;
	end

	// Sequencer: each state does at most one pop and one push on the link memory.
	always_comb begin
		pid_t w;
		qidx_t s;
		qidx_t lq;
		lvl_t lvl_new;
		rem_t rem_new;
		logic [1:0] wait_new;
		logic io_start;

		state_n = state_q;
		cmd_n = cmd_q;
		res_n = res_q;
		head_n = head_q;
		tail_n = tail_q;
		cnt_n = cnt_q;
		resident_n = resident_q;
		sel_lvl_n = sel_lvl_q;
		sel_live_n = sel_live_q;
		first_n = first_q;
		just_exited_n = just_exited_q;
		act_n = act_q;
		p_n = p_q;
		rd_en = 1'b0;
		rd_addr = '0;
		proc_we = 1'b0;
		proc_wa = '0;
		proc_wd = '0;
		link_we = 1'b0;
		link_wa = '0;
		link_wd = '0;
		w = head_q[WAITQ];
		s = qidx_t'(sel_lvl_q);
		lq = '0;
		lvl_new = '0;
		rem_new = '0;
		wait_new = '0;
		io_start = cmd_q.io_request && (cmd_q.burst_phase == PHASE_START);

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_n = cmd;
					res_n = '0;
					state_n = (cmd.action == ACT_ADMIT) ? S_ADMIT : S_WAIT_RD;
				end
			end
			S_ADMIT: begin
				// A new process enters run level 0 unless its slot is taken.
				if (!resident_q[cmd_q.proc_id]) begin
					resident_n[cmd_q.proc_id] = 1'b1;
					proc_we = 1'b1;
					proc_wa = cmd_q.proc_id;
					proc_wd.level = '0;
					proc_wd.remaining = rem_t'({1'b0, cmd_q.run_time});
					proc_wd.wait_left = '0;
					if (cnt_q[0] == '0) begin
						head_n[0] = cmd_q.proc_id;
					end else begin
						link_we = 1'b1;
						link_wa = tail_q[0];
						link_wd = cmd_q.proc_id;
					end
					tail_n[0] = cmd_q.proc_id;
					cnt_n[0] = cnt_q[0] + cnt_t'(1);
				end
				state_n = S_FINISH;
			end
			S_WAIT_RD: begin
				rd_en = 1'b1;
				rd_addr = w;
				state_n = S_WAIT_UPD;
			end
			S_WAIT_UPD: begin
				// The wait-queue head counts down and returns to its run level at zero.
				if (cnt_q[WAITQ] != '0) begin
					wait_new = proc_rd_q.wait_left - 2'd1;
					proc_we = 1'b1;
					proc_wa = w;
					proc_wd = proc_rd_q;
					proc_wd.wait_left = wait_new;
					if (wait_new == '0) begin
						head_n[WAITQ] = link_rd_q;
						cnt_n[WAITQ] = cnt_q[WAITQ] - cnt_t'(1);
						lq = qidx_t'(proc_rd_q.level);
						if (cnt_n[lq] == '0) begin
							head_n[lq] = w;
						end else begin
							link_we = 1'b1;
							link_wa = tail_n[lq];
							link_wd = w;
						end
						tail_n[lq] = w;
						cnt_n[lq] = cnt_n[lq] + cnt_t'(1);
						res_n.io_done_valid = 1'b1;
						res_n.io_done_id = w;
					end
				end
				state_n = S_SEL;
			end
			S_SEL: begin
				if (cmd_q.burst_phase == PHASE_START || first_q || just_exited_q ||
						!sel_live_q) begin
					sel_live_n = pick.found;
					if (pick.found) sel_lvl_n = pick.level;
					just_exited_n = 1'b0;
				end
				state_n = S_RUN_RD;
			end
			S_RUN_RD: begin
				p_n = head_q[s];
				act_n = sel_live_q && (cnt_q[s] != '0);
				rd_en = 1'b1;
				rd_addr = head_q[s];
				state_n = S_RUN_UPD;
			end
			S_RUN_UPD: begin
				if (io_start) begin
					// The selected process leaves for the wait queue one level up.
					if (act_q) begin
						head_n[s] = link_rd_q;
						cnt_n[s] = cnt_q[s] - cnt_t'(1);
						if (cnt_n[WAITQ] == '0) begin
							head_n[WAITQ] = p_q;
						end else begin
							link_we = 1'b1;
							link_wa = tail_n[WAITQ];
							link_wd = p_q;
						end
						tail_n[WAITQ] = p_q;
						cnt_n[WAITQ] = cnt_n[WAITQ] + cnt_t'(1);
						proc_we = 1'b1;
						proc_wa = p_q;
						proc_wd = proc_rd_q;
						proc_wd.wait_left = cmd_q.io_ticks;
						if (proc_rd_q.level < lvl_t'(NUM_LEVELS - 1))
							proc_wd.level = proc_rd_q.level + lvl_t'(1);
					end
					state_n = S_RESEL;
				end else begin
					// The process runs one tick; at burst end it exits or requeues.
					if (act_q) begin
						res_n.run_valid = 1'b1;
						res_n.run_id = p_q;
						res_n.run_level = sel_lvl_q;
						lvl_new = proc_rd_q.level;
						if (cmd_q.burst_phase == PHASE_END && proc_rd_q.level != '0)
							lvl_new = proc_rd_q.level - lvl_t'(1);
						rem_new = proc_rd_q.remaining;
						if (proc_rd_q.remaining != REM_MIN)
							rem_new = proc_rd_q.remaining - rem_t'(1);
						proc_we = 1'b1;
						proc_wa = p_q;
						proc_wd = proc_rd_q;
						proc_wd.level = lvl_new;
						proc_wd.remaining = rem_new;
						if (cmd_q.burst_phase == PHASE_END) begin
							head_n[s] = link_rd_q;
							cnt_n[s] = cnt_q[s] - cnt_t'(1);
							if (rem_new[REM_W-1] || rem_new == '0) begin
								resident_n[p_q] = 1'b0;
								res_n.exited_valid = 1'b1;
								res_n.exited_id = p_q;
								just_exited_n = 1'b1;
							end else begin
								lq = qidx_t'(lvl_new);
								if (cnt_n[lq] == '0) begin
									head_n[lq] = p_q;
								end else begin
									link_we = 1'b1;
									link_wa = tail_n[lq];
									link_wd = p_q;
								end
								tail_n[lq] = p_q;
								cnt_n[lq] = cnt_n[lq] + cnt_t'(1);
							end
						end
					end
					state_n = S_FINISH;
				end
			end
			S_RESEL: begin
				sel_live_n = pick.found;
				if (pick.found) sel_lvl_n = pick.level;
				state_n = S_IO_RUN;
			end
			S_IO_RUN: begin
				if (sel_live_q && cnt_q[s] != '0) begin
					res_n.run_valid = 1'b1;
					res_n.run_id = head_q[s];
					res_n.run_level = sel_lvl_q;
				end
				state_n = S_FINISH;
			end
			S_FINISH: begin
				if (cmd_q.action == ACT_TICK) first_n = 1'b0;
				if (slot_free) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	// Control state and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
			res_q <= '0;
			for (int q = 0; q < NQ; q++) begin
				head_q[q] <= '0;
				tail_q[q] <= '0;
				cnt_q[q] <= '0;
			end
			resident_q <= '0;
			sel_lvl_q <= '0;
			sel_live_q <= 1'b0;
			first_q <= 1'b1;
			just_exited_q <= 1'b0;
			act_q <= 1'b0;
			p_q <= '0;
		end else begin
			state_q <= state_n;
			cmd_q <= cmd_n;
			res_q <= res_n;
			head_q <= head_n;
			tail_q <= tail_n;
			cnt_q <= cnt_n;
			resident_q <= resident_n;
			sel_lvl_q <= sel_lvl_n;
			sel_live_q <= sel_live_n;
			first_q <= first_n;
			just_exited_q <= just_exited_n;
			act_q <= act_n;
			p_q <= p_n;
		end
	end

	// Slot memories with a registered read port.
	always_ff @(posedge clk) begin
		if (proc_we) proc_mem[proc_wa] <= proc_wd;
		if (link_we) link_mem[link_wa] <= link_wd;
		if (rd_en) begin
			proc_rd_q <= proc_mem[rd_addr];
			link_rd_q <= link_mem[rd_addr];
		end
	end
endmodule

// ===== design/mlfq_scheduler_with_io_wait.sv =====
// Multilevel feedback scheduler with an IO wait queue.
// Requests arrive on the cmd channel and results leave on the res channel,
// both valid/ready; a request is taken when valid and ready are high at a
// rising clock edge. Every request yields exactly one result.
// An admit request passes through the admit and finish states. A tick
// request walks the wait-queue read and update, selection, run read and run
// update states, plus a reselection and an IO run state when an IO request
// at burst start forces a second selection, before it finishes. Each queue
// step goes through the slot memory with one registered read.
// One request is worked at a time; cmd.ready is high while the sequencer is
// idle. A finished result sits in an output register, so the next request is
// accepted while the receiver stalls; the sequencer then holds its next
// result until the register is free.
// Reset clears all queues, the selection state and the output register; the
// slot memory itself is not cleared, since entries are written on admit
// before they are read.
module mlfq_scheduler_with_io_wait (
	input logic clk,
	input logic arst_n,
	mlfq_cmd_if.sink cmd,
	mlfq_res_if.source res
);
	import mlfq_pkg::*;

	logic core_idle;
	logic core_done;
	res_t core_res;
	logic slot_free;
	logic out_valid_q;
	res_t out_res_q;

	assign slot_free = !out_valid_q || res.ready;
	assign cmd.ready = core_idle;
	assign res.valid = out_valid_q;
	assign res.payload = out_res_q;

	mlfq_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.valid && core_idle),
		.cmd(cmd.payload),
		.slot_free(slot_free),
		.idle(core_idle),
		.done(core_done),
		.res(core_res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_res_q <= '0;
		end else begin
			if (core_done) begin
				out_valid_q <= 1'b1;
				out_res_q <= core_res;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
